### hdl/pls_pkg.sv
package pls_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CountOW = 9;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_READ,
    S_RESP
  } state_e;

  // one finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic signed [ValueW-1:0]  read_value;
    status_e                   status;
    logic        [CountOW-1:0] count;
    logic                      is_empty;
  } res_t;

endpackage

### hdl/pls_mem.sv
module pls_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pls_ctrl.sv
module pls_ctrl #(
  parameter int unsigned Capacity = 256,
  parameter int unsigned AddrW    = 8,
  parameter int unsigned CountW   = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic [2:0]              opcode_i,
  input  logic [8:0]              position_i,
  input  logic signed [31:0]      value_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output pls_pkg::res_t           res_o,
  output logic                    mem_we_o,
  output logic [AddrW-1:0]        mem_waddr_o,
  output logic [31:0]             mem_wdata_o,
  output logic                    mem_re_o,
  output logic [AddrW-1:0]        mem_raddr_o,
  input  logic [31:0]             mem_rdata_i
);
  import pls_pkg::*;

  localparam int unsigned CmpW = (CountW > PosW) ? CountW : PosW;

  state_e                state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  op_e                   op_q, op_d;
  logic [AddrW-1:0]      pos_q, pos_d;
  logic [31:0]           val_q, val_d;
  logic [AddrW-1:0]      ptr_q, ptr_d;
  logic [AddrW-1:0]      last_q, last_d;
  logic [AddrW-1:0]      wa_q, wa_d;
  logic                  pend_q, pend_d;
  logic signed [31:0]    rd_q, rd_d;
  status_e               status_q, status_d;

  logic                  accept;
  op_e                   op_in;
  logic [CmpW-1:0]       pos_x, cnt_x, cap_x;
  logic                  in_range, ins_range, full;
  logic                  ins_shift, rem_shift;
  logic                  shift_last;
  logic [CmpW-1:0]       count_x;

  assign op_in = op_e'(opcode_i);
  assign pos_x = CmpW'(position_i);
  assign cnt_x = CmpW'(count_q);
  assign cap_x = CmpW'(Capacity);

  assign in_range  = pos_x < cnt_x;
  assign ins_range = pos_x <= cnt_x;
  assign full      = cnt_x >= cap_x;
  assign ins_shift = pos_x < cnt_x;
  assign rem_shift = (pos_x + CmpW'(1)) < cnt_x;
  assign accept    = req_valid_i && (state_q == S_IDLE);
  assign shift_last = (ptr_q == last_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_RESP;
          case (op_in)
            OP_INSERT: begin
              if (ins_range && !full) begin
                state_d = ins_shift ? S_SHIFT : S_PUT;
              end
            end
            OP_REMOVE: begin
              if (in_range && rem_shift) begin
                state_d = S_SHIFT;
              end
            end
            OP_SET: begin
              if (in_range) begin
                state_d = S_PUT;
              end
            end
            OP_GET: begin
              if (in_range) begin
                state_d = S_READ;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = (op_q == OP_INSERT) ? S_PUT : S_RESP;
      S_PUT:   state_d = S_RESP;
      S_READ:  state_d = S_RESP;
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: handshake and memory port
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        mem_re_o    = req_valid_i && (op_in == OP_GET);
        mem_raddr_o = AddrW'(position_i);
      end
      S_SHIFT: begin
        mem_re_o = 1'b1;
        mem_we_o = pend_q;
      end
      S_DRAIN: mem_we_o = 1'b1;
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
      end
      S_READ: ;
      S_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    count_d  = count_q;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    ptr_d    = ptr_q;
    last_d   = last_q;
    wa_d     = wa_q;
    rd_d     = rd_q;
    status_d = status_q;
    pend_d   = (state_q == S_SHIFT);
    if (accept) begin
      op_d     = op_in;
      pos_d    = AddrW'(position_i);
      val_d    = value_i;
      rd_d     = '0;
      status_d = ST_OK;
      case (op_in)
        OP_INSERT: begin
          if (!ins_range) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            // walk down from the top entry to the insert point
            ptr_d   = AddrW'(count_q - CountW'(1));
            last_d  = AddrW'(position_i);
            count_d = count_q + CountW'(1);
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            // walk up from just above the hole to the top entry
            ptr_d   = AddrW'(position_i) + AddrW'(1);
            last_d  = AddrW'(count_q - CountW'(1));
            count_d = count_q - CountW'(1);
          end
        end
        OP_SET, OP_GET: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end
        end
        OP_CLEAR: count_d = '0;
        default: ;
      endcase
    end
    if (state_q == S_SHIFT) begin
      if (op_q == OP_INSERT) begin
        ptr_d = ptr_q - AddrW'(1);
        wa_d  = ptr_q + AddrW'(1);
      end else begin
        ptr_d = ptr_q + AddrW'(1);
        wa_d  = ptr_q - AddrW'(1);
      end
    end
    if (state_q == S_READ) begin
      rd_d = mem_rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    last_q   <= last_d;
    wa_q     <= wa_d;
    rd_q     <= rd_d;
    status_q <= status_d;
  end

  assign count_x = CmpW'(count_q);

  always_comb begin
    res_o.read_value = rd_q;
    res_o.status     = status_q;
    res_o.count      = count_x[CountOW-1:0];
    res_o.is_empty   = (count_q == '0);
  end

endmodule

### hdl/positional_list_store.sv
// positional_list_store: an ordered list of up to CAPACITY signed 32-bit
// entries held in one synchronous ram (one write and one read port, read
// data registered) plus an entry count register. Each request transaction
// is insert, remove, set, get or clear at a position and returns exactly one
// result transaction with the read value, a status (ok, position out of
// range, store full), the new count (low 9 bits) and an empty flag. Only one
// request is worked on at a time; the input is ready again once the result
// has moved into the output register, so the next request can be taken while
// that result still waits. Insert moves every entry at or above the
// position, and remove every entry above it, one place through the ram,
// one per cycle (read at one address, write the previous read back one
// slot further on). Clear only resets the count, so there is no ram
// clearing pass after reset.
module positional_list_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          opcode_i,
  input  logic [8:0]          position_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  read_value_o,
  output logic [1:0]          status_o,
  output logic [8:0]          count_o,
  output logic                is_empty_o
);
  import pls_pkg::*;

  // address and count widths follow the capacity
  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  // ram port between sequencer and storage
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [31:0]       mem_rdata;

  // finished result from the sequencer
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // output register
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  pls_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CountW   (CountW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pls_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // the output register takes a new result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.read_value;
  assign status_o     = out_q.status;
  assign count_o      = out_q.count;
  assign is_empty_o   = out_q.is_empty;

endmodule
